// ===== rtl/core/pclkt_pkg.sv =====
// ----------------------------------------------------------------------------
// pclkt_pkg
// Shared widths, codes and control types of the per-channel LFU key table.
// ----------------------------------------------------------------------------
package pclkt_pkg;

   localparam int KEY_W        = 64;
   localparam int HITS_W       = 32;
   localparam int STAMP_W      = 48;
   localparam int SUM_W        = 35;
   localparam int CHAN_W       = 4;
   localparam int STATUS_W     = 3;
   localparam int SLOT_OUT_W   = 3;
   localparam int UNIQUE_W     = 4;
   localparam int CAP_REG_W    = 4;
   localparam int CCOUNT_REG_W = 5;

   localparam int REQ_TDATA_W  = 120;
   localparam int RSP_TDATA_W  = 80;

   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_CAP    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 1'b1;

   localparam logic [CAP_REG_W-1:0]    CAP_RESET    = 4'd8;
   localparam logic [CCOUNT_REG_W-1:0] CCOUNT_RESET = 5'd16;

   localparam logic [HITS_W-1:0] HITS_MAX = '1;

   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [HITS_W-1:0]  hits;
      logic [STAMP_W-1:0] stamp;
   } record_type;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_step;
      logic finish;
   } pclkt_cmd_type;

   typedef struct packed {
      logic skip_scan;
      logic scan_last;
      logic out_busy;
   } pclkt_stat_type;

endpackage

// ===== rtl/core/pclkt_ram.sv =====
// ----------------------------------------------------------------------------
// pclkt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pclkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pclkt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pclkt_ctrl
// Sequencer: accept, fetch occupancy, scan the channel row unless the scan is skipped, commit and respond.
// ----------------------------------------------------------------------------
module pclkt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  pclkt_pkg::pclkt_stat_type stat,
   output pclkt_pkg::pclkt_cmd_type  cmd
);
   import pclkt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_USED = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_tready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_USED;
            end
         end
         S_USED: begin
            cmd.scan_init = 1'b1;
            state_in      = stat.skip_scan ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_fetches: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_USED))
      else $error("accepted transfer did not start occupancy fetch");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && stat.scan_last) |=> (state_ff == S_DONE))
      else $error("scan did not end on last slot");

   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == S_IDLE && !cmd.finish))
      else $error("commit not followed by idle");

endmodule

// ===== rtl/core/pclkt_dp.sv =====
// ----------------------------------------------------------------------------
// pclkt_dp
// Datapath: configuration, record and occupancy memories, slot scan with
// match and victim search, running hit sum, commit and response register.
// ----------------------------------------------------------------------------
module pclkt_dp #(
   parameter int NUM_CHANNELS = 16,
   parameter int MAX_RECORDS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_clear,
   input  logic [pclkt_pkg::CHAN_W-1:0]         in_channel,
   input  logic [pclkt_pkg::KEY_W-1:0]          in_key,
   input  logic [pclkt_pkg::STAMP_W-1:0]        in_stamp,
   input  logic                                 csr_wr_en,
   input  logic [pclkt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pclkt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [pclkt_pkg::STATUS_W-1:0]       out_status,
   output logic [pclkt_pkg::SLOT_OUT_W-1:0]     out_slot,
   output logic [pclkt_pkg::UNIQUE_W-1:0]       out_unique,
   output logic [pclkt_pkg::SUM_W-1:0]          out_hits,
   output logic [pclkt_pkg::SUM_W-1:0]          out_repeats,
   input  pclkt_pkg::pclkt_cmd_type              cmd,
   output pclkt_pkg::pclkt_stat_type             stat
);
   import pclkt_pkg::*;

   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SLOT_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam int DEPTH  = NUM_CHANNELS * MAX_RECORDS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CAP_W  = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;
   localparam int LIM_W  = 7;

   // configuration
   logic [CAP_REG_W-1:0]    record_cap_ff;
   logic [CCOUNT_REG_W-1:0] channel_count_ff;

   // item
   logic               clear_ff, clear_in;
   logic [CHAN_W-1:0]  ch_ff, ch_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic               ch_ok_ff, ch_ok_in;

   // scan
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  match_ff, match_in;
   logic [HITS_W-1:0]  match_hits_ff, match_hits_in;
   logic [SLOT_W-1:0]  victim_ff, victim_in;
   logic [HITS_W-1:0]  victim_hits_ff, victim_hits_in;
   logic [STAMP_W-1:0] victim_stamp_ff, victim_stamp_in;

   logic [NUM_CHANNELS-1:0] valid_ff, valid_in;

   // response
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic [UNIQUE_W-1:0]   rsp_unique_ff;
   logic [SUM_W-1:0]      rsp_hits_ff;
   logic [SUM_W-1:0]      rsp_repeats_ff;

   // memories
   logic [CH_W-1:0]   ch_idx;
   logic [CH_W-1:0]   used_rd_addr;
   logic [CNT_W-1:0]  used_rd;
   logic [CNT_W-1:0]  used_eff;
   logic [CNT_W-1:0]  used_wdata;
   logic [ADDR_W-1:0] base;
   logic [SLOT_W-1:0] rd_slot;
   logic [ADDR_W-1:0] rec_rd_addr;
   logic [ADDR_W-1:0] rec_wr_addr;
   record_type        rec_rd;
   record_type        rec_wr;

   // commit
   logic              scan_last;
   logic              better;
   logic              hit_sat;
   logic              cap_zero;
   logic              room;
   logic [STATUS_W-1:0] status_sel;
   logic [SLOT_W-1:0] slot_sel;
   logic [CNT_W-1:0]  used_new;
   logic [SUM_W-1:0]  sum_new;
   logic              rec_we;
   logic              used_we;
   logic [HITS_W-1:0] wr_hits;

   always_ff @(posedge clock) begin
      if (reset) begin
         record_cap_ff    <= CAP_RESET;
         channel_count_ff <= CCOUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RECORD_CAP:    record_cap_ff    <= csr_wdata[CAP_REG_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CCOUNT_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign ch_idx       = CH_W'(ch_ff);
   assign used_rd_addr = cmd.load ? CH_W'(in_channel) : ch_idx;
   assign used_eff     = valid_ff[ch_idx] ? used_rd : '0;
   assign base         = ADDR_W'(ch_idx) * ADDR_W'(MAX_RECORDS);
   assign scan_last    = (CNT_W'(idx_ff) + CNT_W'(1)) == used_ff;
   assign rd_slot      = cmd.scan_init ? '0 : (scan_last ? idx_ff : idx_ff + SLOT_W'(1));
   assign rec_rd_addr  = base + ADDR_W'(rd_slot);
   assign rec_wr_addr  = base + ADDR_W'(slot_sel);

   assign stat.skip_scan = !ch_ok_ff || clear_ff || (used_eff == '0);
   assign stat.scan_last = scan_last;
   assign stat.out_busy  = rsp_valid_ff && !rsp_tready;

   assign better = (idx_ff == '0) || (rec_rd.hits < victim_hits_ff) ||
                   ((rec_rd.hits == victim_hits_ff) && (rec_rd.stamp < victim_stamp_ff));

   always_comb begin
      clear_in        = clear_ff;
      ch_in           = ch_ff;
      key_in          = key_ff;
      stamp_in        = stamp_ff;
      ch_ok_in        = ch_ok_ff;
      used_in         = used_ff;
      idx_in          = idx_ff;
      sum_in          = sum_ff;
      found_in        = found_ff;
      match_in        = match_ff;
      match_hits_in   = match_hits_ff;
      victim_in       = victim_ff;
      victim_hits_in  = victim_hits_ff;
      victim_stamp_in = victim_stamp_ff;
      if (cmd.load) begin
         clear_in = in_clear;
         ch_in    = in_channel;
         key_in   = in_key;
         stamp_in = in_stamp;
         ch_ok_in = ({1'b0, in_channel} < channel_count_ff) &&
                    (LIM_W'(in_channel) < LIM_W'(NUM_CHANNELS));
      end
      if (cmd.scan_init) begin
         used_in  = used_eff;
         idx_in   = '0;
         sum_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + SLOT_W'(1);
         sum_in = sum_ff + SUM_W'(rec_rd.hits);
         if (!found_ff && (rec_rd.key == key_ff)) begin
            found_in      = 1'b1;
            match_in      = idx_ff;
            match_hits_in = rec_rd.hits;
         end
         if (better) begin
            victim_in       = idx_ff;
            victim_hits_in  = rec_rd.hits;
            victim_stamp_in = rec_rd.stamp;
         end
      end
   end

   assign hit_sat  = (match_hits_ff == HITS_MAX);
   assign cap_zero = (record_cap_ff == '0);
   assign room     = (CAP_W'(used_ff) < CAP_W'(record_cap_ff)) &&
                     (CAP_W'(used_ff) < CAP_W'(MAX_RECORDS));

   always_comb begin
      status_sel = ST_IGNORED;
      slot_sel   = '0;
      used_new   = used_ff;
      sum_new    = sum_ff;
      rec_we     = 1'b0;
      used_we    = 1'b0;
      wr_hits    = HITS_W'(1);
      if (!ch_ok_ff) begin
         used_new = '0;
         sum_new  = '0;
      end else if (clear_ff) begin
         status_sel = ST_CLEARED;
         used_new   = '0;
         sum_new    = '0;
         used_we    = 1'b1;
      end else if (key_ff == '0) begin
         status_sel = ST_IGNORED;
      end else if (found_ff) begin
         status_sel = ST_HIT;
         slot_sel   = match_ff;
         sum_new    = sum_ff + SUM_W'(!hit_sat);
         wr_hits    = hit_sat ? match_hits_ff : match_hits_ff + HITS_W'(1);
         rec_we     = 1'b1;
      end else if (cap_zero) begin
         status_sel = ST_DROPPED;
      end else if (room) begin
         status_sel = ST_INSERTED;
         slot_sel   = SLOT_W'(used_ff);
         used_new   = used_ff + CNT_W'(1);
         sum_new    = sum_ff + SUM_W'(1);
         rec_we     = 1'b1;
         used_we    = 1'b1;
      end else begin
         status_sel = ST_REPLACED;
         slot_sel   = victim_ff;
         sum_new    = sum_ff - SUM_W'(victim_hits_ff) + SUM_W'(1);
         rec_we     = 1'b1;
      end
   end

   assign rec_wr.key   = key_ff;
   assign rec_wr.hits  = wr_hits;
   assign rec_wr.stamp = stamp_ff;
   assign used_wdata   = used_new;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish && used_we) begin
         valid_in[ch_idx] = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clear_ff        <= clear_in;
      ch_ff           <= ch_in;
      key_ff          <= key_in;
      stamp_ff        <= stamp_in;
      ch_ok_ff        <= ch_ok_in;
      used_ff         <= used_in;
      idx_ff          <= idx_in;
      sum_ff          <= sum_in;
      found_ff        <= found_in;
      match_ff        <= match_in;
      match_hits_ff   <= match_hits_in;
      victim_ff       <= victim_in;
      victim_hits_ff  <= victim_hits_in;
      victim_stamp_ff <= victim_stamp_in;
      if (cmd.finish) begin
         rsp_status_ff  <= status_sel;
         rsp_slot_ff    <= SLOT_OUT_W'(slot_sel);
         rsp_unique_ff  <= UNIQUE_W'(used_new);
         rsp_hits_ff    <= sum_new;
         rsp_repeats_ff <= sum_new - SUM_W'(used_new);
      end
   end

   pclkt_ram #(
      .WIDTH ($bits(record_type)),
      .DEPTH (DEPTH)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (cmd.finish && rec_we),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd)
   );

   pclkt_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_CHANNELS)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (cmd.finish && used_we),
      .wr_addr (ch_idx),
      .wr_data (used_wdata),
      .rd_addr (used_rd_addr),
      .rd_data (used_rd)
   );

   assign rsp_tvalid  = rsp_valid_ff;
   assign out_status  = rsp_status_ff;
   assign out_slot    = rsp_slot_ff;
   assign out_unique  = rsp_unique_ff;
   assign out_hits    = rsp_hits_ff;
   assign out_repeats = rsp_repeats_ff;

endmodule

// ===== rtl/core/per_channel_lfu_key_table.sv =====
// ----------------------------------------------------------------------------
// per_channel_lfu_key_table
// Per-channel key table with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer: observe a key or clear a channel.
//   rsp_* returns exactly one result per request: outcome, slot and the
//   channel summary (records held, total hits, repeat events).
//   csr_* writes record_cap (index 0) and channel_count (index 1); write only
//   while no request is in flight.
// Timing:
//   A request steps through accepting, fetching the occupancy, reading each
//   record the channel holds (0 to MAX_RECORDS) through the single read port
//   of the record memory, and committing. The result is registered;
//   req_tready is high only when the sequencer is idle. Cleared, unused or
//   empty channels skip the record reads.
// Reset:
//   Synchronous, active high. All channels read as empty, registers return to
//   cap 8 and 16 channels; record memory contents are not cleared.
// Backpressure:
//   A result waits in the output register while rsp_tready is low; the next
//   request is accepted and scanned, and holds at commit until it drains.
// ----------------------------------------------------------------------------
module per_channel_lfu_key_table #(
   parameter int NUM_CHANNELS = 16,
   parameter int MAX_RECORDS  = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [pclkt_pkg::REQ_TDATA_W-1:0]       req_tdata,  // channel, key, step_stamp
   input  logic                                    req_tuser,  // cmd
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [pclkt_pkg::RSP_TDATA_W-1:0]       rsp_tdata,  // slot, unique_keys,
                                                               // channel_hits, repeat_events
   output logic [pclkt_pkg::STATUS_W-1:0]          rsp_tuser,  // status
   input  logic                                    csr_wr_en,
   input  logic [pclkt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pclkt_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import pclkt_pkg::*;

   localparam int CH_LO    = 0;
   localparam int KEY_LO   = CH_LO + CHAN_W;
   localparam int STAMP_LO = KEY_LO + KEY_W;
   localparam int REQ_USED = STAMP_LO + STAMP_W;

   localparam int SLOT_LO  = 0;
   localparam int UNIQ_LO  = SLOT_LO + SLOT_OUT_W;
   localparam int HITS_LO  = UNIQ_LO + UNIQUE_W;
   localparam int REP_LO   = HITS_LO + SUM_W;
   localparam int RSP_USED = REP_LO + SUM_W;

   pclkt_cmd_type  cmd;
   pclkt_stat_type stat;

   logic [SLOT_OUT_W-1:0] out_slot;
   logic [UNIQUE_W-1:0]   out_unique;
   logic [SUM_W-1:0]      out_hits;
   logic [SUM_W-1:0]      out_repeats;

   pclkt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pclkt_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .MAX_RECORDS  (MAX_RECORDS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .in_clear    (req_tuser),
      .in_channel  (req_tdata[KEY_LO-1:CH_LO]),
      .in_key      (req_tdata[STAMP_LO-1:KEY_LO]),
      .in_stamp    (req_tdata[REQ_USED-1:STAMP_LO]),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .out_status  (rsp_tuser),
      .out_slot    (out_slot),
      .out_unique  (out_unique),
      .out_hits    (out_hits),
      .out_repeats (out_repeats),
      .cmd         (cmd),
      .stat        (stat)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_USED){1'b0}},
                       out_repeats, out_hits, out_unique, out_slot};

endmodule

// ===== verif/per_channel_lfu_key_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_lfu_key_table_tb
// Self-checking bench for the per-channel LFU key table.
// A scoreboard class keeps its own copy of every channel's records. It works
// out each response from the accepted requests and compares every field of
// the responses that come back. Directed requests cover empty, full, tied and
// cleared channels. Random requests follow, under several cap and
// channel-count settings, with random gaps, backpressure and one long
// response stall.
// ----------------------------------------------------------------------------
module per_channel_lfu_key_table_tb;
   import pclkt_pkg::*;

   localparam int NUM_CH  = 16;
   localparam int MAX_REC = 8;
   localparam logic CMD_OBSERVE = 1'b0;
   localparam logic CMD_CLEAR   = 1'b1;
   localparam int POOL_SIZE = 12;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [UNIQUE_W-1:0]   key_count;
      logic [SUM_W-1:0]      hits_sum;
      logic [SUM_W-1:0]      repeat_sum;
   } table_result_type;

   class lfu_table_scoreboard;
      logic [KEY_W-1:0]   rec_key   [NUM_CH][MAX_REC];
      logic [HITS_W-1:0]  rec_hits  [NUM_CH][MAX_REC];
      logic [STAMP_W-1:0] rec_stamp [NUM_CH][MAX_REC];
      int unsigned        held [NUM_CH];
      int unsigned        cap_reg;
      int unsigned        ccount_reg;
      table_result_type   expected_q [$];
      int                 errors;
      int                 status_seen [8];

      function new();
         foreach (held[c]) held[c] = 0;
         foreach (status_seen[s]) status_seen[s] = 0;
         cap_reg    = CAP_RESET;
         ccount_reg = CCOUNT_RESET;
         errors     = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_RECORD_CAP) cap_reg = val[CAP_REG_W-1:0];
         else ccount_reg = val[CCOUNT_REG_W-1:0];
      endfunction

      function void note_request(logic cmd, logic [CHAN_W-1:0] ch,
                                 logic [KEY_W-1:0] key, logic [STAMP_W-1:0] stamp);
         table_result_type r;
         int unsigned      lim, cap, u, v;
         bit               found;
         r     = '0;
         found = 0;
         lim   = ccount_reg < NUM_CH ? ccount_reg : NUM_CH;
         cap   = cap_reg < MAX_REC ? cap_reg : MAX_REC;
         if (ch < lim) begin
            u = held[ch];
            if (cmd == CMD_CLEAR) begin
               held[ch] = 0;
               r.status = ST_CLEARED;
            end else if (key != '0) begin
               for (int s = 0; s < u && !found; s++) begin
                  if (rec_key[ch][s] == key) begin
                     if (rec_hits[ch][s] != HITS_MAX) rec_hits[ch][s]++;
                     rec_stamp[ch][s] = stamp;
                     r.status = ST_HIT;
                     r.slot   = SLOT_OUT_W'(s);
                     found    = 1;
                  end
               end
               if (!found) begin
                  if (cap == 0) begin
                     r.status = ST_DROPPED;
                  end else if (u < cap) begin
                     rec_key[ch][u]   = key;
                     rec_hits[ch][u]  = 1;
                     rec_stamp[ch][u] = stamp;
                     held[ch] = u + 1;
                     r.status = ST_INSERTED;
                     r.slot   = SLOT_OUT_W'(u);
                  end else begin
                     // fewest hits, then oldest stamp, then lowest slot
                     v = 0;
                     for (int s = 1; s < u; s++) begin
                        if (rec_hits[ch][s] < rec_hits[ch][v] ||
                            (rec_hits[ch][s] == rec_hits[ch][v] &&
                             rec_stamp[ch][s] < rec_stamp[ch][v]))
                           v = s;
                     end
                     rec_key[ch][v]   = key;
                     rec_hits[ch][v]  = 1;
                     rec_stamp[ch][v] = stamp;
                     r.status = ST_REPLACED;
                     r.slot   = SLOT_OUT_W'(v);
                  end
               end
            end
            r.key_count = UNIQUE_W'(held[ch]);
            for (int s = 0; s < held[ch]; s++) begin
               r.hits_sum += rec_hits[ch][s];
               if (rec_hits[ch][s] > 1) r.repeat_sum += rec_hits[ch][s] - 1;
            end
         end
         expected_q.insert(expected_q.size(), r);
      endfunction

      task report_mismatch(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
         errors++;
         $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      endtask

      task check_result(logic [STATUS_W-1:0] status, logic [RSP_TDATA_W-1:0] tdata);
         table_result_type got, want;
         got.status     = status;
         got.slot       = tdata[2:0];
         got.key_count  = tdata[6:3];
         got.hits_sum   = tdata[41:7];
         got.repeat_sum = tdata[76:42];
         status_seen[status]++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response, status", status, 0);
            return;
         end
         want = expected_q.pop_front();
         if (got.status != want.status) report_mismatch("status", got.status, want.status);
         if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
         if (got.key_count != want.key_count)
            report_mismatch("key_count", got.key_count, want.key_count);
         if (got.hits_sum != want.hits_sum)
            report_mismatch("channel_hits", got.hits_sum, want.hits_sum);
         if (got.repeat_sum != want.repeat_sum)
            report_mismatch("repeat_events", got.repeat_sum, want.repeat_sum);
      endtask
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_W-1:0]    req_tdata  = '0;
   logic                      req_tuser  = CMD_OBSERVE;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;
   logic [STATUS_W-1:0]       rsp_tuser;
   logic                      csr_wr_en  = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index  = CSR_RECORD_CAP;
   logic [CSR_DATA_W-1:0]     csr_wdata  = '0;

   lfu_table_scoreboard sb = new();

   bit                  calm = 0;
   int                  sent = 0;
   int                  received = 0;
   int                  hold_left = 0;
   bit                  hold_done = 0;
   logic [KEY_W-1:0]    key_pool [POOL_SIZE];
   logic [STAMP_W-1:0]  stamp_now = '0;

   per_channel_lfu_key_table #(
      .NUM_CHANNELS (NUM_CH),
      .MAX_RECORDS  (MAX_REC)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // response side: random backpressure plus one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tuser, rsp_tdata);
         received++;
      end
      if (!hold_done && received == 60) begin
         hold_done = 1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 10);
      end
   end

   task send_item(logic cmd, logic [CHAN_W-1:0] ch, logic [KEY_W-1:0] key,
                  logic [STAMP_W-1:0] stamp);
      if (!calm && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0, stamp, key, ch};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, ch, key, stamp);
      sent++;
   endtask

   task wait_drained();
      int guard;
      guard = 0;
      while (sb.expected_q.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task set_config(int unsigned cap, int unsigned ccount);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_RECORD_CAP;
      csr_wdata <= CSR_DATA_W'(cap);
      sb.set_reg(CSR_RECORD_CAP, CSR_DATA_W'(cap));
      @(posedge clock);
      csr_index <= CSR_CHANNEL_COUNT;
      csr_wdata <= CSR_DATA_W'(ccount);
      sb.set_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(ccount));
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task run_random(int count);
      logic [CHAN_W-1:0]  ch;
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
      logic               cmd;
      int                 pick;
      for (int i = 0; i < count; i++) begin
         cmd = ($urandom_range(99) < 3) ? CMD_CLEAR : CMD_OBSERVE;
         ch  = CHAN_W'(($urandom_range(99) < 70) ? $urandom_range(3)
                                                 : $urandom_range(NUM_CH - 1));
         pick = $urandom_range(99);
         if (pick < 3) key = '0;
         else if (pick < 13) key = {$urandom, $urandom};
         else if (pick < 55) key = key_pool[$urandom_range(3)];
         else key = key_pool[$urandom_range(POOL_SIZE - 1)];
         if ($urandom_range(99) < 10) begin
            stamp = STAMP_W'({$urandom, $urandom});
         end else begin
            stamp_now += $urandom_range(3);
            stamp = stamp_now;
         end
         send_item(cmd, ch, key, stamp);
      end
   endtask

   initial begin
      foreach (key_pool[k]) key_pool[k] = {$urandom, $urandom};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // empty channel, extreme key and stamp, hit, clear, refill
      send_item(CMD_OBSERVE, 0, '0, 48'd1);
      send_item(CMD_OBSERVE, 0, '1, '1);
      send_item(CMD_OBSERVE, 0, '1, 48'd5);
      send_item(CMD_OBSERVE, 0, 64'd1, '0);
      send_item(CMD_CLEAR,   0, {$urandom, $urandom}, 48'd6);
      send_item(CMD_OBSERVE, 0, 64'd1, 48'd7);
      // fill the top channel with equal stamps, then force tied replacements
      for (int i = 0; i < MAX_REC; i++)
         send_item(CMD_OBSERVE, 4'hF, 64'h100 + i, 48'd7);
      send_item(CMD_OBSERVE, 4'hF, 64'h103, 48'd9);
      send_item(CMD_OBSERVE, 4'hF, 64'hA000_0000_0000_0001, 48'd20);
      send_item(CMD_OBSERVE, 4'hF, 64'hA000_0000_0000_0002, 48'd21);
      send_item(CMD_OBSERVE, 4'hF, 64'h105, 48'd3);
      send_item(CMD_OBSERVE, 4'hF, 64'hA000_0000_0000_0003, 48'd22);
      send_item(CMD_OBSERVE, 4'hF, '0, 48'd23);
      send_item(CMD_CLEAR,   4'hF, '0, 48'd24);

      // cap zero: a held key still hits, new keys are dropped
      set_config(0, 16);
      send_item(CMD_OBSERVE, 0, 64'd1, 48'd30);
      send_item(CMD_OBSERVE, 0, 64'd2, 48'd31);
      send_item(CMD_OBSERVE, 3, 64'd5, 48'd32);
      stamp_now = 48'd100;

      set_config(8, 16);
      run_random(300);
      set_config(3, 16);
      run_random(150);
      set_config(0, 16);
      run_random(60);
      calm = 1;
      set_config(15, 31);
      run_random(150);
      calm = 0;
      set_config(1, 5);
      run_random(100);
      set_config(0, 0);
      run_random(30);
      set_config(8, 1);
      run_random(100);
      set_config(2, 16);
      run_random(100);

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      while (sb.expected_q.size() != 0) begin
         void'(sb.expected_q.pop_front());
         sb.report_mismatch("response never arrived, pending", sb.expected_q.size(), 0);
      end
      $display("Sent %0d requests over caps 0..15 and channel counts 0..31, received %0d.",
               sent, received);
      $display("Outcomes: ignored %0d, hit %0d, inserted %0d, replaced %0d, dropped %0d, cleared %0d.",
               sb.status_seen[ST_IGNORED], sb.status_seen[ST_HIT],
               sb.status_seen[ST_INSERTED], sb.status_seen[ST_REPLACED],
               sb.status_seen[ST_DROPPED], sb.status_seen[ST_CLEARED]);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout after %0d requests, %0d responses.", sent, received);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/pclkt_pkg.sv
rtl/core/pclkt_ram.sv
rtl/core/pclkt_ctrl.sv
rtl/core/pclkt_dp.sv
rtl/core/per_channel_lfu_key_table.sv
verif/per_channel_lfu_key_table_tb.sv
